/* hw/rtl/brf_pkg.sv */
// Shared types and constants of the byte ring FIFO: field widths, request
// codes, the result word and the store command.
// No dependencies; compile first.
package brf_pkg;

  localparam int unsigned ReqTypeW    = 3;
  localparam int unsigned CountW      = 4;
  localparam int unsigned DataW       = 64;
  localparam int unsigned LevelW      = 11;
  localparam int unsigned BytesPerReq = 8;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_DRAIN = 3'd3,
    REQ_CLEAR = 3'd4
  } req_type_e;

  typedef struct packed {
    logic [LevelW-1:0] done_count;
    logic [DataW-1:0]  read_bytes;
    logic [LevelW-1:0] fill_level;
    logic [LevelW-1:0] space_left;
    logic              write_rejected;
  } rsp_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

/* hw/rtl/brf_req_if.sv */
// Request channel of the byte ring FIFO: valid/ready plus request fields.
// Depends on brf_pkg.
interface brf_req_if import brf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [CountW-1:0]   byte_count;
  logic [DataW-1:0]    write_bytes;
  logic [LevelW-1:0]   drain_count;

  modport source (output valid, req_type, byte_count, write_bytes, drain_count,
                  input ready);
  modport sink   (input valid, req_type, byte_count, write_bytes, drain_count,
                  output ready);
endinterface

/* hw/rtl/brf_rsp_if.sv */
// Result channel of the byte ring FIFO: valid/ready plus result fields.
// Depends on brf_pkg.
interface brf_rsp_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] done_count;
  logic [DataW-1:0]  read_bytes;
  logic [LevelW-1:0] fill_level;
  logic [LevelW-1:0] space_left;
  logic              write_rejected;

  modport source (output valid, done_count, read_bytes, fill_level, space_left,
                  write_rejected, input ready);
  modport sink   (input valid, done_count, read_bytes, fill_level, space_left,
                  write_rejected, output ready);
endinterface

/* hw/rtl/brf_store.sv */
// Byte store: single-port synchronous RAM, one byte read or written per cycle,
// registered read data. Depends on brf_pkg.
module brf_store import brf_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  mem_cmd_t      cmd_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/brf_ctrl.sv */
// Request sequencer: holds the pointers, decides each request and walks the
// byte store one byte per cycle. Depends on brf_pkg.
module brf_ctrl import brf_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned PW = AW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [ReqTypeW-1:0] req_type_i,
  input  logic [CountW-1:0]   byte_count_i,
  input  logic [DataW-1:0]    write_bytes_i,
  input  logic [LevelW-1:0]   drain_count_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output rsp_t                res_o,
  output mem_cmd_t            mem_cmd_o,
  output logic [AW-1:0]       mem_addr_o,
  output logic [7:0]          mem_wdata_o,
  input  logic [7:0]          mem_rdata_i
);

  localparam int unsigned     CW     = (PW > LevelW) ? PW : LevelW;
  localparam logic [PW-1:0]   DepthP = PW'(DEPTH);
  localparam logic [CountW-1:0] BprC = CountW'(BytesPerReq);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [PW-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic                pend_q, pend_d;
  logic [ReqTypeW-1:0] type_q, type_d;
  logic [CountW-1:0]   n_q, n_d, i_q, i_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [DataW-1:0]    wdata_q, wdata_d, rdata_q, rdata_d;
  logic [LevelW-1:0]   done_q, done_d;
  logic                rej_q, rej_d;
  logic [2:0]          slot_q, slot_d;

  logic [PW-1:0]     fill_c;
  logic [CW-1:0]     fill_x, cnt_x, space_x, drain_x, dclip_x, rp_drain_x;
  logic [CW-1:0]     wp_adv_x, rp_adv_x;
  logic [CountW-1:0] cnt_c, rclip_c;
  logic              issue, is_wr, is_rd;

  assign fill_c     = wp_q - rp_q;
  assign fill_x     = CW'(fill_c);
  assign cnt_c      = (byte_count_i > BprC) ? BprC : byte_count_i;
  assign cnt_x      = CW'(cnt_c);
  assign space_x    = CW'(DepthP - fill_c);
  assign drain_x    = CW'(drain_count_i);
  assign dclip_x    = (drain_x > fill_x) ? fill_x : drain_x;
  assign rp_drain_x = CW'(rp_q) + dclip_x;
  assign rclip_c    = (cnt_x > fill_x) ? fill_x[CountW-1:0] : cnt_c;
  assign wp_adv_x   = CW'(wp_q) + CW'(n_q);
  assign rp_adv_x   = CW'(rp_q) + CW'(n_q);

  assign is_wr = (type_q == REQ_WRITE);
  assign is_rd = (type_q == REQ_READ) || (type_q == REQ_PEEK);
  assign issue = (state_q == StRun) && (i_q != n_q);

  assign req_ready_o     = (state_q == StIdle);
  assign res_valid_o     = (state_q == StFin);
  assign mem_cmd_o.wr_en = issue && is_wr;
  assign mem_cmd_o.rd_en = issue && is_rd;
  assign mem_addr_o      = addr_q;
  assign mem_wdata_o     = wdata_q[{i_q[2:0], 3'b000} +: 8];

  assign res_o.done_count     = done_q;
  assign res_o.read_bytes     = rdata_q;
  assign res_o.fill_level     = LevelW'(fill_c);
  assign res_o.space_left     = LevelW'(DepthP - fill_c);
  assign res_o.write_rejected = rej_q;

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    pend_d  = pend_q;
    type_d  = type_q;
    n_d     = n_q;
    i_d     = i_q;
    addr_d  = addr_q;
    wdata_d = wdata_q;
    rdata_d = rdata_q;
    done_d  = done_q;
    rej_d   = rej_q;
    slot_d  = slot_q;
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          state_d = StRun;
          type_d  = req_type_i;
          i_d     = '0;
          n_d     = '0;
          wdata_d = write_bytes_i;
          rdata_d = '0;
          done_d  = '0;
          rej_d   = 1'b0;
          pend_d  = 1'b0;
          addr_d  = rp_q[AW-1:0];
          case (req_type_i)
            REQ_WRITE: begin
              addr_d = wp_q[AW-1:0];
              // all or nothing: reject the whole word when room is short
              if (space_x < cnt_x) begin
                rej_d = 1'b1;
              end else begin
                n_d    = cnt_c;
                done_d = LevelW'(cnt_c);
              end
            end
            REQ_READ, REQ_PEEK: begin
              n_d    = rclip_c;
              done_d = LevelW'(rclip_c);
            end
            REQ_DRAIN: begin
              rp_d   = rp_drain_x[PW-1:0];
              done_d = LevelW'(dclip_x);
            end
            REQ_CLEAR: begin
              wp_d = '0;
              rp_d = '0;
            end
            default: ;
          endcase
        end
      end
      StRun: begin
        pend_d = issue && is_rd;
        if (issue) begin
          addr_d = addr_q + 1'b1;
          i_d    = i_q + 1'b1;
          slot_d = i_q[2:0];
        end
        // read data lands in the cycle after its address
        if (pend_q) begin
          rdata_d[{slot_q, 3'b000} +: 8] = mem_rdata_i;
        end
        if (!issue && !pend_q) begin
          state_d = StFin;
          if (is_wr) begin
            wp_d = wp_adv_x[PW-1:0];
          end
          if (type_q == REQ_READ) begin
            rp_d = rp_adv_x[PW-1:0];
          end
        end
      end
      StFin: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wp_q    <= '0;
      rp_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    n_q     <= n_d;
    i_q     <= i_d;
    addr_q  <= addr_d;
    wdata_q <= wdata_d;
    rdata_q <= rdata_d;
    done_q  <= done_d;
    rej_q   <= rej_d;
    slot_q  <= slot_d;
  end

endmodule

/* hw/rtl/byte_ring_fifo.sv */
// Byte ring FIFO top level: sequencer, byte store and result register.
// Depends on brf_pkg, brf_req_if, brf_rsp_if, brf_store, brf_ctrl.
//
//   channel | dir | fields
//   --------+-----+------------------------------------------------------------
//   req_i   | in  | req_type, byte_count, write_bytes, drain_count
//   rsp_o   | out | done_count, read_bytes, fill_level, space_left, write_rejected
//
// A request of n bytes (after clipping) moves its bytes through the single
// byte port of the store one at a time; a read or peek then waits for the
// registered read data of its last byte. Drain, clear, rejected writes and
// empty reads touch no byte of the store. The next request is taken only
// after the result has moved to the output register.
// Reset clears the pointers, the sequencer state and the output valid flag; the store needs no clearing pass.
// A new request is taken while a result waits in the output register; the
// next result then holds until that register is freed.
module byte_ring_fifo import brf_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_req_if.sink   req_i,
  brf_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  mem_cmd_t      mem_cmd;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          res_valid, res_take;
  rsp_t          res;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q;

  brf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_type_i    (req_i.req_type),
    .byte_count_i  (req_i.byte_count),
    .write_bytes_i (req_i.write_bytes),
    .drain_count_i (req_i.drain_count),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res),
    .mem_cmd_o     (mem_cmd),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  brf_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // load the output register when empty or being emptied this cycle
  assign res_take    = res_valid && (!out_valid_q || rsp_o.ready);
  assign out_valid_d = res_take ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.done_count     = out_q.done_count;
  assign rsp_o.read_bytes     = out_q.read_bytes;
  assign rsp_o.fill_level     = out_q.fill_level;
  assign rsp_o.space_left     = out_q.space_left;
  assign rsp_o.write_rejected = out_q.write_rejected;

  a_level_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.fill_level + rsp_o.space_left) == LevelW'(DEPTH)))
    else $error("fill level and free space do not add up to the depth");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.write_rejected) |-> (rsp_o.done_count == '0))
    else $error("rejected write reports a nonzero count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while the previous one is still in progress");

  a_store_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_cmd.wr_en && mem_cmd.rd_en))
    else $error("store read and written in the same cycle");

endmodule

/* tb/byte_ring_fifo_test.sv */
// Self-checking bench for the byte ring FIFO: directed table, random bursts of
// requests, checked word by word against the table or an in-bench ring model.
// Depends on brf_pkg, brf_req_if, brf_rsp_if and byte_ring_fifo.
module byte_ring_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned RANDOM_ITEMS = 1425;
  localparam int unsigned PHASE_LEN    = 150;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned PLAN_ROWS    = 24;

  // request codes the block leaves unused
  localparam logic [ReqTypeW-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [ReqTypeW-1:0] REQ_SPARE_MID   = 3'd6;
  localparam logic [ReqTypeW-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [CountW-1:0]   byte_count;
    logic [DataW-1:0]    write_bytes;
    logic [LevelW-1:0]   drain_count;
  } fifo_req_t;

  typedef struct packed {
    fifo_req_t req;
    logic      typed;
    rsp_t      rsp;
  } plan_row_t;

  typedef enum int {BURST_FILL, BURST_EMPTY, BURST_MIXED, BURST_NOISE} burst_e;

  localparam rsp_t EMPTY_RSP = '{11'd0, 64'h0, 11'd0, 11'd1024, 1'b0};
  localparam rsp_t NO_RSP    = '0;

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{'{REQ_READ,  4'd8,  64'h0, 11'd0},    1'b1, EMPTY_RSP},
    '{'{REQ_PEEK,  4'd8,  64'h0, 11'd0},    1'b1, EMPTY_RSP},
    '{'{REQ_DRAIN, 4'd0,  64'h0, 11'd2047}, 1'b1, EMPTY_RSP},
    '{'{REQ_WRITE, 4'd0,  64'hDEAD_BEEF_CAFE_F00D, 11'd0}, 1'b1, EMPTY_RSP},
    '{'{REQ_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 11'd0}, 1'b1,
      '{11'd8, 64'h0, 11'd8, 11'd1016, 1'b0}},
    '{'{REQ_PEEK,  4'd15, 64'h0, 11'd0},    1'b1,
      '{11'd8, 64'hFFFF_FFFF_FFFF_FFFF, 11'd8, 11'd1016, 1'b0}},
    '{'{REQ_READ,  4'd3,  64'h0, 11'd0},    1'b1,
      '{11'd3, 64'h0000_0000_00FF_FFFF, 11'd5, 11'd1019, 1'b0}},
    '{'{REQ_WRITE, 4'd9,  64'h0123_4567_89AB_CDEF, 11'd0}, 1'b1,
      '{11'd8, 64'h0, 11'd13, 11'd1011, 1'b0}},
    '{'{REQ_WRITE, 4'd1,  64'hFFFF_FFFF_FFFF_FF5A, 11'd0}, 1'b0, NO_RSP},
    '{'{REQ_SPARE_FIRST, 4'd8, 64'h1234, 11'd5}, 1'b1,
      '{11'd0, 64'h0, 11'd14, 11'd1010, 1'b0}},
    '{'{REQ_SPARE_MID,   4'd8, 64'h1234, 11'd5}, 1'b1,
      '{11'd0, 64'h0, 11'd14, 11'd1010, 1'b0}},
    '{'{REQ_SPARE_LAST,  4'd8, 64'h1234, 11'd5}, 1'b1,
      '{11'd0, 64'h0, 11'd14, 11'd1010, 1'b0}},
    '{'{REQ_PEEK,  4'd0,  64'h0, 11'd0},    1'b1,
      '{11'd0, 64'h0, 11'd14, 11'd1010, 1'b0}},
    '{'{REQ_READ,  4'd8,  64'h0, 11'd0},    1'b0, NO_RSP},
    '{'{REQ_PEEK,  4'd15, 64'h0, 11'd0},    1'b0, NO_RSP},
    '{'{REQ_DRAIN, 4'd0,  64'h0, 11'd2},    1'b0, NO_RSP},
    '{'{REQ_READ,  4'd1,  64'h0, 11'd0},    1'b0, NO_RSP},
    '{'{REQ_DRAIN, 4'd0,  64'h0, 11'd2047}, 1'b0, NO_RSP},
    '{'{REQ_WRITE, 4'd5,  64'h8877_6655_4433_2211, 11'd0}, 1'b0, NO_RSP},
    '{'{REQ_CLEAR, 4'd8,  64'h0, 11'd2047}, 1'b1, EMPTY_RSP},
    '{'{REQ_READ,  4'd8,  64'h0, 11'd0},    1'b1, EMPTY_RSP},
    '{'{REQ_WRITE, 4'd8,  64'h0, 11'd0},    1'b1,
      '{11'd8, 64'h0, 11'd8, 11'd1016, 1'b0}},
    '{'{REQ_READ,  4'd15, 64'h0, 11'd0},    1'b1,
      '{11'd8, 64'h0, 11'd0, 11'd1024, 1'b0}},
    '{'{REQ_WRITE, 4'd4,  64'hA5A5_A5A5_C3B2_A190, 11'd0}, 1'b0, NO_RSP}
  };

  logic clk_i;
  logic rst_ni;

  brf_req_if req_if ();
  brf_rsp_if rsp_if ();

  byte_ring_fifo #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // ring model state
  logic [7:0]        ring_mem [DEPTH];
  logic [LevelW-1:0] wr_ptr;
  logic [LevelW-1:0] rd_ptr;

  rsp_t        due_rsp [$];
  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic rsp_t ring_apply(input fifo_req_t r);
    rsp_t              o;
    logic [LevelW-1:0] fill;
    int unsigned       cnt;
    int unsigned       n_drop;
    o    = '0;
    fill = wr_ptr - rd_ptr;
    cnt  = (r.byte_count > BytesPerReq) ? BytesPerReq : r.byte_count;
    case (r.req_type)
      REQ_WRITE: begin
        if (DEPTH - fill < cnt) begin
          o.write_rejected = 1'b1;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            ring_mem[IDX_W'(wr_ptr + LevelW'(i))] = r.write_bytes[8*i +: 8];
          end
          wr_ptr       = LevelW'(wr_ptr + cnt);
          o.done_count = LevelW'(cnt);
        end
      end
      REQ_READ, REQ_PEEK: begin
        if (cnt > fill) cnt = fill;
        for (int i = 0; i < cnt; i++) begin
          o.read_bytes[8*i +: 8] = ring_mem[IDX_W'(rd_ptr + LevelW'(i))];
        end
        o.done_count = LevelW'(cnt);
        if (r.req_type == REQ_READ) rd_ptr = LevelW'(rd_ptr + cnt);
      end
      REQ_DRAIN: begin
        n_drop       = (r.drain_count > fill) ? fill : r.drain_count;
        rd_ptr       = LevelW'(rd_ptr + n_drop);
        o.done_count = LevelW'(n_drop);
      end
      REQ_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      default: ;
    endcase
    o.fill_level = wr_ptr - rd_ptr;
    o.space_left = LevelW'(DEPTH - o.fill_level);
    return o;
  endfunction

  function automatic fifo_req_t random_req(input burst_e burst);
    fifo_req_t   r;
    int unsigned pick;
    pick          = $urandom_range(99);
    r.write_bytes = {$urandom, $urandom};
    r.byte_count  = ($urandom_range(99) < 75) ? 4'd8 : 4'($urandom_range(0, 15));
    r.drain_count = ($urandom_range(99) < 85) ? 11'($urandom_range(0, 40))
                                              : 11'($urandom_range(0, 2047));
    case (burst)
      BURST_FILL: begin
        if (pick < 88)      r.req_type = REQ_WRITE;
        else if (pick < 94) r.req_type = REQ_PEEK;
        else                r.req_type = REQ_READ;
      end
      BURST_EMPTY: begin
        if (pick < 45)      r.req_type = REQ_READ;
        else if (pick < 70) r.req_type = REQ_DRAIN;
        else if (pick < 85) r.req_type = REQ_PEEK;
        else begin
          r.req_type   = REQ_WRITE;
          r.byte_count = 4'($urandom_range(0, 3));
        end
      end
      BURST_MIXED: begin
        if (pick < 2)      r.req_type = REQ_CLEAR;
        else if (pick < 5) r.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        else               r.req_type = 3'($urandom_range(REQ_WRITE, REQ_DRAIN));
      end
      default: begin
        r.req_type    = 3'($urandom_range(0, 7));
        r.byte_count  = 4'($urandom_range(0, 15));
        r.drain_count = 11'($urandom_range(0, 2047));
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // Idle settings rotate with the word count: none, sender, receiver, both.
  task automatic send_word(input fifo_req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t        predicted;
    int unsigned phase;
    logic        took;
    phase         = (n_sent / PHASE_LEN) % 4;
    src_idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 37 : 0;
    snk_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 37 : 0;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req_type;
    req_if.byte_count  <= r.byte_count;
    req_if.write_bytes <= r.write_bytes;
    req_if.drain_count <= r.drain_count;
    // sample ready mid-cycle, where it has settled
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = (req_if.ready === 1'b1);
      @(posedge clk_i);
    end
    predicted = ring_apply(r);
    due_rsp.push_back(typed ? typed_rsp : predicted);
    n_sent++;
  endtask

  // check mid-cycle: valid, ready and the word hold until the next rising edge
  always @(negedge clk_i) begin : rsp_check
    rsp_t want;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (due_rsp.size() == 0) begin
        $error("result word with nothing outstanding");
        n_fail++;
      end else begin
        want = due_rsp.pop_front();
        check_field("done_count", want.done_count, rsp_if.done_count);
        check_field("read_bytes", want.read_bytes, rsp_if.read_bytes);
        check_field("fill_level", want.fill_level, rsp_if.fill_level);
        check_field("space_left", want.space_left, rsp_if.space_left);
        check_field("write_rejected", want.write_rejected, rsp_if.write_rejected);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_pace
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    fifo_req_t   r;
    burst_e      burst;
    int unsigned burst_len;
    int unsigned n_random;
    int unsigned pick;
    n_fail             = 0;
    n_sent             = 0;
    n_random           = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    wr_ptr             = '0;
    rd_ptr             = '0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_WRITE;
    req_if.byte_count  <= '0;
    req_if.write_bytes <= '0;
    req_if.drain_count <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_word(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].rsp);
    end

    // open with a fill burst so the ring reaches full and rejects early
    burst = BURST_FILL;
    while (n_random < RANDOM_ITEMS) begin
      case (burst)
        BURST_FILL:  burst_len = $urandom_range(40, 170);
        BURST_EMPTY: burst_len = $urandom_range(10, 60);
        BURST_MIXED: burst_len = $urandom_range(20, 80);
        default:     burst_len = $urandom_range(3, 12);
      endcase
      for (int i = 0; i < burst_len; i++) begin
        r = random_req(burst);
        send_word(r, 1'b0, NO_RSP);
        if (r.req_type <= REQ_CLEAR) n_random++;
      end
      pick = $urandom_range(99);
      if (pick < 30)      burst = BURST_FILL;
      else if (pick < 55) burst = BURST_EMPTY;
      else if (pick < 90) burst = BURST_MIXED;
      else                burst = BURST_NOISE;
    end

    // drop valid, release the receiver and let the pipe drain
    req_if.valid  <= 1'b0;
    snk_stall_pct = 0;
    while (due_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/brf_pkg.sv
hw/rtl/brf_req_if.sv
hw/rtl/brf_rsp_if.sv
hw/rtl/brf_store.sv
hw/rtl/brf_ctrl.sv
hw/rtl/byte_ring_fifo.sv
tb/byte_ring_fifo_test.sv
